@@ rtl/core/chorus_pkg.sv @@
// Shared types and fixed constants of the chorus delay block.
// Used by controller, datapath, sine ROM and top level; no dependencies.
package chorus_pkg;

    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 20;
    localparam int MOD_DEPTH_W   = 17;
    localparam int LFO_INC_W     = 20;
    localparam int BASE_DELAY_W  = 11;
    localparam int PHASE_W       = 32;
    localparam int SINE_W        = 16;
    localparam int SWING_W       = 18;
    localparam int FRAC_W        = 8;
    localparam int MIX_SHIFT     = 15;

    localparam logic [CFG_INDEX_W-1:0] CFG_MOD_DEPTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LFO_INC    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BASE_DELAY = 2'd2;

    localparam logic [MOD_DEPTH_W-1:0]  MOD_DEPTH_RESET  = 17'd32768;
    localparam logic [MOD_DEPTH_W-1:0]  MOD_DEPTH_HIGH   = 17'd65536;
    localparam logic [LFO_INC_W-1:0]    LFO_INC_RESET    = 20'd146072;
    localparam logic [LFO_INC_W-1:0]    LFO_INC_LOW      = 20'd9738;
    localparam logic [LFO_INC_W-1:0]    LFO_INC_HIGH     = 20'd973810;
    localparam logic [BASE_DELAY_W-1:0] BASE_DELAY_RESET = 11'd1102;

    // 0.7 in Q15
    localparam logic signed [15:0] MIX_DRY_GAIN = 16'sd22938;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SINE,
        S_SWING,
        S_DELAY,
        S_ADDR,
        S_RD1,
        S_RD2,
        S_RD3,
        S_MIX,
        S_COMMIT
    } t_state;

    typedef struct packed {
        logic capture;
        logic swing;
        logic delay;
        logic addr;
        logic rd1;
        logic rd2;
        logic rd3;
        logic mix;
        logic commit;
    } t_cmd;

endpackage

@@ rtl/core/chorus_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module chorus_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/chorus_sine_rom.sv @@
// Sine table, Q1.15, built at elaboration from a quarter-wave polynomial.
// Registered read. Depends on chorus_pkg.
module chorus_sine_rom import chorus_pkg::*; #(
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  logic                                i_clk,
    input  logic [$clog2(SINE_TABLE_DEPTH)-1:0] i_index,
    output logic signed [SINE_W-1:0]            o_value
);

    localparam longint Q30 = 64'sd1073741824;

    typedef logic signed [SINE_W-1:0] t_rom [SINE_TABLE_DEPTH];

    // sin(pi/2 * t), t and result in Q30, products truncated toward zero
    function automatic longint quarter_wave(input longint t);
        longint t2;
        longint p;
        t2 = t * t / Q30;
        p  = 172272;
        p  = -5026998 + p * t2 / Q30;
        p  = 85569306 + p * t2 / Q30;
        p  = -693598671 + p * t2 / Q30;
        p  = 1686629713 + p * t2 / Q30;
        return p * t / Q30;
    endfunction

    function automatic t_rom build_rom();
        t_rom   rom;
        longint k4;
        longint quad;
        longint rem;
        longint t;
        longint v;
        longint r;
        for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
            k4   = 4 * longint'(k);
            quad = k4 / SINE_TABLE_DEPTH;
            rem  = k4 % SINE_TABLE_DEPTH;
            t    = (rem <<< 30) / SINE_TABLE_DEPTH;
            if ((quad % 2) == 1) begin
                t = Q30 - t;
            end
            v = quarter_wave(t);
            if (v < 0) begin
                v = 0;
            end
            r = (v + 16384) / 32768;
            if (r > 32767) begin
                r = 32767;
            end
            if (quad >= 2) begin
                r = -r;
            end
            rom[k] = SINE_W'(r);
        end
        return rom;
    endfunction

    localparam t_rom SINE_ROM = build_rom();

    logic signed [SINE_W-1:0] r_value;

    always_ff @(posedge i_clk) begin
        r_value <= SINE_ROM[i_index];
    end

    assign o_value = r_value;

endmodule

@@ rtl/core/chorus_ctrl.sv @@
// Sequencer for one sample: steps the datapath through oscillator, delay,
// tap reads, mix and commit. Depends on chorus_pkg.
module chorus_ctrl import chorus_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    t_cmd   w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.capture = 1'b1;
                    n_state       = S_SINE;
                end
            end
            S_SINE: begin
                n_state = S_SWING;
            end
            S_SWING: begin
                w_cmd.swing = 1'b1;
                n_state     = S_DELAY;
            end
            S_DELAY: begin
                w_cmd.delay = 1'b1;
                n_state     = S_ADDR;
            end
            S_ADDR: begin
                w_cmd.addr = 1'b1;
                n_state    = S_RD1;
            end
            S_RD1: begin
                w_cmd.rd1 = 1'b1;
                n_state   = S_RD2;
            end
            S_RD2: begin
                w_cmd.rd2 = 1'b1;
                n_state   = S_RD3;
            end
            S_RD3: begin
                w_cmd.rd3 = 1'b1;
                n_state   = S_MIX;
            end
            S_MIX: begin
                w_cmd.mix = 1'b1;
                n_state   = S_COMMIT;
            end
            S_COMMIT: begin
                // hold until the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    w_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = w_cmd;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_SINE))
        else $error("accepted request did not start the sequence");

    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |=> o_out_valid)
        else $error("committed result not presented");

    a_mix_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MIX) |-> ($past(r_state) == S_RD3))
        else $error("mix reached without both tap reads");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> !w_cmd.commit)
        else $error("result overwritten while stalled");

endmodule

@@ rtl/core/chorus_dp.sv @@
// Datapath: configuration, oscillator, delay arithmetic, delay store, mix.
// Depends on chorus_pkg, chorus_ram and chorus_sine_rom.
module chorus_dp import chorus_pkg::*; #(
    parameter int DELAY_DEPTH      = 2048,
    parameter int SAMPLE_BITS      = 16,
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cmd                          i_cmd,
    input  logic                          i_cfg_we,
    input  logic [CFG_INDEX_W-1:0]        i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_in,
    output logic signed [SAMPLE_BITS-1:0] o_sample_out
);

    localparam int AW    = $clog2(DELAY_DEPTH);
    localparam int FW    = $clog2(DELAY_DEPTH + 1);
    localparam int IW    = $clog2(SINE_TABLE_DEPTH);
    localparam int SW    = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int D_W   = (AW + 9 > 21) ? AW + 9 : 21;
    localparam int TAP_W = SAMPLE_BITS + 10;
    localparam int MIX_W = SAMPLE_BITS + 18;
    localparam int Y_W   = MIX_W - MIX_SHIFT;

    localparam logic [AW:0]             DEPTH_EXT = (AW + 1)'(DELAY_DEPTH);
    localparam logic [AW-1:0]           LAST_ADDR = AW'(DELAY_DEPTH - 1);
    localparam logic [FW-1:0]           FILL_FULL = FW'(DELAY_DEPTH);
    localparam logic [SW-1:0]           SINE_D    = SW'(SINE_TABLE_DEPTH);
    localparam logic signed [D_W-1:0]   D_MIN     = D_W'(256);
    localparam logic signed [D_W-1:0]   D_MAX     = D_W'(DELAY_DEPTH * 256 - 1);
    localparam logic signed [MIX_W-1:0] MIX_ROUND = MIX_W'(2 ** (MIX_SHIFT - 1));
    localparam logic signed [Y_W-1:0]   Y_MAX     = Y_W'(2 ** (SAMPLE_BITS - 1) - 1);
    localparam logic signed [Y_W-1:0]   Y_MIN     = Y_W'(-(2 ** (SAMPLE_BITS - 1)));

    logic [MOD_DEPTH_W-1:0]         r_mod_depth;
    logic [LFO_INC_W-1:0]           r_lfo_inc;
    logic [BASE_DELAY_W-1:0]        r_base;
    logic [PHASE_W-1:0]             r_phase;
    logic [AW-1:0]                  r_wp;
    logic [FW-1:0]                  r_fill;
    logic signed [SAMPLE_BITS-1:0]  r_sample;
    logic [IW-1:0]                  r_idx;
    logic [SWING_W-1:0]             r_swing;
    logic                           r_neg;
    logic [AW-1:0]                  r_whole;
    logic [FRAC_W-1:0]              r_frac;
    logic [AW-1:0]                  r_p1;
    logic [AW-1:0]                  r_p2;
    logic                           r_valid1;
    logic                           r_valid2;
    logic signed [TAP_W-1:0]        r_tap1;
    logic signed [TAP_W-1:0]        r_tap2;
    logic signed [MIX_W-1:0]        r_mix;
    logic signed [SAMPLE_BITS-1:0]  r_out;

    logic [MOD_DEPTH_W-1:0]         w_cfg_depth;
    logic [LFO_INC_W-1:0]           w_cfg_inc;
    logic [PHASE_W+SW-1:0]          w_idx_prod;
    logic signed [SINE_W-1:0]       w_sine;
    logic [SINE_W-2:0]              w_mag;
    logic [31:0]                    w_swing_prod;
    logic signed [D_W-1:0]          w_base_q;
    logic signed [D_W-1:0]          w_swing_s;
    logic signed [D_W-1:0]          w_d;
    logic signed [D_W-1:0]          w_dc;
    logic [AW:0]                    w_sum;
    logic [AW-1:0]                  w_p1;
    logic [AW-1:0]                  w_p2;
    logic [AW-1:0]                  w_raddr;
    logic signed [SAMPLE_BITS-1:0]  w_rdata;
    logic [FRAC_W:0]                w_wt1;
    logic signed [TAP_W-1:0]        w_tapped;
    logic signed [MIX_W-1:0]        w_mix;
    logic signed [Y_W-1:0]          w_y;
    logic signed [SAMPLE_BITS-1:0]  w_sat;

    chorus_sine_rom #(
        .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
    ) u_sine_rom (
        .i_clk   (i_clk),
        .i_index (r_idx),
        .o_value (w_sine)
    );

    chorus_ram #(
        .WIDTH(SAMPLE_BITS),
        .DEPTH(DELAY_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit),
        .i_waddr (r_wp),
        .i_wdata (r_sample),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // clamp modulation-depth and LFO-increment writes to their legal ranges
    always_comb begin
        w_cfg_depth = i_cfg_data[MOD_DEPTH_W-1:0];
        if (w_cfg_depth > MOD_DEPTH_HIGH) begin
            w_cfg_depth = MOD_DEPTH_HIGH;
        end
        w_cfg_inc = i_cfg_data[LFO_INC_W-1:0];
        if (w_cfg_inc < LFO_INC_LOW) begin
            w_cfg_inc = LFO_INC_LOW;
        end
        if (w_cfg_inc > LFO_INC_HIGH) begin
            w_cfg_inc = LFO_INC_HIGH;
        end
    end

    assign w_idx_prod   = (PHASE_W + SW)'(r_phase) * (PHASE_W + SW)'(SINE_D);
    assign w_mag        = (w_sine < 0) ? (SINE_W - 1)'(-w_sine) : w_sine[SINE_W-2:0];
    assign w_swing_prod = 32'(r_mod_depth) * 32'(w_mag);

    // Q11.8 delay, kept inside the store: at least one sample, below the store depth
    always_comb begin
        w_base_q  = D_W'({r_base, 8'd0});
        w_swing_s = D_W'(r_swing);
        w_d       = r_neg ? (w_base_q - w_swing_s) : (w_base_q + w_swing_s);
        w_dc      = w_d;
        if (w_d < D_MIN) begin
            w_dc = D_MIN;
        end
        if (w_d > D_MAX) begin
            w_dc = D_MAX;
        end
    end

    assign w_sum   = {1'b0, r_wp} + DEPTH_EXT - (AW + 1)'(r_whole);
    assign w_p1    = (w_sum >= DEPTH_EXT) ? AW'(w_sum - DEPTH_EXT) : w_sum[AW-1:0];
    assign w_p2    = (r_p1 == '0) ? LAST_ADDR : (r_p1 - AW'(1));
    assign w_raddr = i_cmd.rd2 ? r_p2 : r_p1;

    assign w_wt1    = (FRAC_W + 1)'(256) - {1'b0, r_frac};
    assign w_tapped = r_tap1 + r_tap2;
    assign w_mix    = MIX_W'(r_sample) * MIX_W'(MIX_DRY_GAIN)
                    + (MIX_W'(w_tapped) <<< 6) + MIX_ROUND;

    always_comb begin
        w_y   = Y_W'(r_mix >>> MIX_SHIFT);
        w_sat = SAMPLE_BITS'(w_y);
        if (w_y > Y_MAX) begin
            w_sat = SAMPLE_BITS'(Y_MAX);
        end
        if (w_y < Y_MIN) begin
            w_sat = SAMPLE_BITS'(Y_MIN);
        end
    end

    // configuration and persistent state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod_depth <= MOD_DEPTH_RESET;
            r_lfo_inc   <= LFO_INC_RESET;
            r_base      <= BASE_DELAY_RESET;
            r_phase     <= '0;
            r_wp        <= '0;
            r_fill      <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MOD_DEPTH:  r_mod_depth <= w_cfg_depth;
                    CFG_LFO_INC:    r_lfo_inc   <= w_cfg_inc;
                    CFG_BASE_DELAY: r_base      <= i_cfg_data[BASE_DELAY_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.commit) begin
                r_phase <= r_phase + PHASE_W'(r_lfo_inc);
                r_wp    <= (r_wp == LAST_ADDR) ? '0 : (r_wp + AW'(1));
                if (r_fill != FILL_FULL) begin
                    r_fill <= r_fill + FW'(1);
                end
            end
        end
    end

    // per-sample working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_sample <= i_sample_in;
            r_idx    <= w_idx_prod[PHASE_W +: IW];
        end
        if (i_cmd.swing) begin
            r_swing <= w_swing_prod[31:14];
            r_neg   <= (w_sine < 0);
        end
        if (i_cmd.delay) begin
            r_whole <= w_dc[AW+7:8];
            r_frac  <= w_dc[FRAC_W-1:0];
        end
        if (i_cmd.addr) begin
            r_p1 <= w_p1;
        end
        // slots beyond the fill count were never written and read as zero
        if (i_cmd.rd1) begin
            r_p2     <= w_p2;
            r_valid1 <= (FW'(r_p1) < r_fill);
        end
        if (i_cmd.rd2) begin
            r_valid2 <= (FW'(r_p2) < r_fill);
            r_tap1   <= r_valid1 ? TAP_W'(w_rdata) * TAP_W'(signed'({1'b0, w_wt1}))
                                 : '0;
        end
        if (i_cmd.rd3) begin
            r_tap2 <= r_valid2 ? TAP_W'(w_rdata) * TAP_W'(signed'({1'b0, r_frac}))
                               : '0;
        end
        if (i_cmd.mix) begin
            r_mix <= w_mix;
        end
        if (i_cmd.commit) begin
            r_out <= w_sat;
        end
    end

    assign o_sample_out = r_out;

endmodule

@@ rtl/core/chorus_modulated_delay.sv @@
// Chorus: sine-modulated, linearly interpolated delay mixed with the dry sample.
// Samples are taken one at a time: a new request is stalled until the step
// sequencer has finished the last one, which includes two reads of the single
// delay-store read port and a commit that waits while the output is stalled.
// Reset (synchronous, active low) restores register defaults, pointer and phase;
// the store needs no clearing pass, a fill count masks slots not yet written.
module chorus_modulated_delay import chorus_pkg::*; #(
    parameter int DELAY_DEPTH      = 2048,
    parameter int SAMPLE_BITS      = 16,
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_in,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [SAMPLE_BITS-1:0] o_sample_out,
    input  logic                          i_cfg_we,
    input  logic [CFG_INDEX_W-1:0]        i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data
);

    t_cmd w_cmd;

    chorus_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd)
    );

    chorus_dp #(
        .DELAY_DEPTH     (DELAY_DEPTH),
        .SAMPLE_BITS     (SAMPLE_BITS),
        .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_sample_in  (i_sample_in),
        .o_sample_out (o_sample_out)
    );

endmodule
